// ===== design/csb_pkg.sv =====
// Shared types and constants for the CDF table sample binning unit.
// Used by csb_ctrl, csb_dp and the top level; depends on nothing.
`default_nettype none

package csb_pkg;

    localparam int MAX_BINS   = 128;
    localparam int COUNT_BITS = 24;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int N_W   = $clog2(MAX_BINS + 1);

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 17;
    localparam int BIN_W   = 7;
    localparam int COUNT_W = 24;
    localparam int CFG_W   = 8;

    localparam int CMP_W = (N_W > CFG_W) ? N_W : CFG_W;

    localparam logic [CFG_W-1:0] BINS_RST = 8'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_BIN  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_START,
        ST_STEP,
        ST_CNT_RD,
        ST_CNT_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        RES_LOAD,
        RES_MISS,
        RES_HIT_CNT,
        RES_READ,
        RES_BAD_RD
    } t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     issue;
        logic     step;
        logic     thr_wr;
        logic     cnt_rd;
        logic     cnt_upd;
        logic     res_set;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic idx_ok;
        logic empty;
        logic step_last;
        logic found;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/csb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output      logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/csb_ctrl.sv =====
// Controller state machine of the sample binning unit.
// Drives datapath commands from status; uses csb_pkg.
`default_nettype none

module csb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    output      logic             o_s_ready,
    input  wire logic             i_m_ready,
    output      logic             o_m_valid,
    input  wire csb_pkg::t_dp_sts i_sts,
    output      csb_pkg::t_dp_cmd o_cmd
);
    import csb_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_vld;
    logic    n_out_vld;
    logic    s_fire;
    t_dp_cmd cmd;

    assign s_fire    = i_s_valid && o_s_ready;
    assign o_m_valid = r_out_vld;
    assign o_cmd     = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        cmd       = '0;
        cmd.res_sel = RES_MISS;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_SIMPLE;
                end
            end
            ST_SIMPLE: begin
                unique case (i_sts.cmd)
                    CMD_LOAD: begin
                        cmd.thr_wr  = 1'b1;
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_LOAD;
                        n_state     = ST_DONE;
                    end
                    CMD_BIN: begin
                        n_state = ST_START;
                    end
                    CMD_READ: begin
                        n_state = ST_CNT_RD;
                    end
                    CMD_NONE: begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_MISS;
                        n_state     = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_START: begin
                if (i_sts.empty) begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_MISS;
                    n_state     = ST_DONE;
                end else begin
                    cmd.issue = 1'b1;
                    n_state   = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = ST_CNT_RD;
                end
            end
            ST_CNT_RD: begin
                if (i_sts.cmd == CMD_BIN) begin
                    if (i_sts.found) begin
                        cmd.cnt_rd = 1'b1;
                        n_state    = ST_CNT_UPD;
                    end else begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_MISS;
                        n_state     = ST_DONE;
                    end
                end else begin
                    if (i_sts.idx_ok) begin
                        cmd.cnt_rd = 1'b1;
                        n_state    = ST_CNT_UPD;
                    end else begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_BAD_RD;
                        n_state     = ST_DONE;
                    end
                end
            end
            ST_CNT_UPD: begin
                cmd.cnt_upd = 1'b1;
                cmd.res_set = 1'b1;
                cmd.res_sel = (i_sts.cmd == CMD_BIN) ? RES_HIT_CNT : RES_READ;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_m_ready) begin
            n_out_vld = 1'b0;
        end
    end

    a_fire_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_state != ST_IDLE)
        else $error("input transfer did not start work");

    a_step_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STEP |=> (r_state == ST_STEP || r_state == ST_CNT_RD))
        else $error("search left to an unexpected state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_ready) |=> (r_out_vld && $stable(r_state == ST_IDLE) == 1'b1)
            || r_out_vld)
        else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== design/csb_dp.sv =====
// Datapath of the sample binning unit: threshold and count memories,
// binary search range, count update, result and output registers. Uses csb_pkg, csb_ram.
`default_nettype none

module csb_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [csb_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [csb_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [csb_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [csb_pkg::VALUE_W-1:0]   i_value,
    output      logic                          o_hit,
    output      logic [csb_pkg::BIN_W-1:0]     o_bin,
    output      logic [csb_pkg::COUNT_W-1:0]   o_count,
    input  wire csb_pkg::t_dp_cmd              i_cmd_dp,
    output      csb_pkg::t_dp_sts              o_sts
);
    import csb_pkg::*;

    logic [CFG_W-1:0]      r_bins;
    t_cmd                  r_cmd;
    logic [INDEX_W-1:0]    r_index;
    logic [VALUE_W-1:0]    r_value;
    logic [N_W-1:0]        r_n;
    logic [N_W-1:0]        r_lo;
    logic [N_W-1:0]        r_hi;
    logic [IDX_W-1:0]      r_mid;
    logic [MAX_BINS-1:0]   r_cnt_vld;
    logic                  r_cnt_vld_q;
    logic [IDX_W-1:0]      r_cnt_addr;
    logic                  r_res_hit;
    logic [BIN_W-1:0]      r_res_bin;
    logic [COUNT_BITS-1:0] r_res_count;
    logic                  r_out_hit;
    logic [BIN_W-1:0]      r_out_bin;
    logic [COUNT_BITS-1:0] r_out_count;

    logic [CMP_W-1:0]      idx_ext;
    logic                  idx_ok;
    logic [IDX_W-1:0]      idx_addr;
    logic [N_W-1:0]        n_clamp;
    logic [N_W-1:0]        mid_cur;
    logic [N_W-1:0]        mid_ext;
    logic [N_W-1:0]        n_lo;
    logic [N_W-1:0]        n_hi;
    logic [N_W-1:0]        mid_nxt;
    logic                  gt;
    logic [IDX_W-1:0]      thr_raddr;
    logic [VALUE_W-1:0]    thr_rdata;
    logic [IDX_W-1:0]      cnt_addr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  cnt_we;

    assign o_cfg_ready = 1'b1;

    assign idx_ext  = CMP_W'(r_index);
    assign idx_ok   = idx_ext < CMP_W'(MAX_BINS);
    assign idx_addr = idx_ext[IDX_W-1:0];
    assign n_clamp  = (CMP_W'(r_bins) > CMP_W'(MAX_BINS)) ? N_W'(MAX_BINS) : N_W'(r_bins);

    assign mid_cur = N_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign mid_ext = N_W'(r_mid);
    assign gt      = thr_rdata > r_value;
    assign n_lo    = gt ? r_lo : N_W'(mid_ext + 1'b1);
    assign n_hi    = gt ? mid_ext : r_hi;
    assign mid_nxt = N_W'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);

    assign thr_raddr = i_cmd_dp.step ? mid_nxt[IDX_W-1:0] : mid_cur[IDX_W-1:0];
    assign cnt_addr  = (r_cmd == CMD_BIN) ? r_lo[IDX_W-1:0] : idx_addr;

    assign cnt_cur = r_cnt_vld_q ? cnt_rdata : '0;
    assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;
    assign cnt_we  = i_cmd_dp.cnt_upd && (r_cmd == CMD_BIN);

    assign o_sts.cmd       = r_cmd;
    assign o_sts.idx_ok    = idx_ok;
    assign o_sts.empty     = r_lo == r_hi;
    assign o_sts.step_last = n_lo == n_hi;
    assign o_sts.found     = r_lo < r_n;

    assign o_hit   = r_out_hit;
    assign o_bin   = r_out_bin;
    assign o_count = COUNT_W'(r_out_count);

    csb_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_BINS)
    ) u_thr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd_dp.thr_wr && idx_ok),
        .i_waddr (idx_addr),
        .i_wdata (r_value),
        .i_raddr (thr_raddr),
        .o_rdata (thr_rdata)
    );

    csb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_cnt_addr),
        .i_wdata (cnt_inc),
        .i_raddr (cnt_addr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins    <= BINS_RST;
            r_cnt_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bins <= i_cfg_data;
            end
            if (cnt_we) begin
                r_cnt_vld[r_cnt_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.capture) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_index <= i_index;
            r_value <= i_value;
            r_n     <= n_clamp;
            r_lo    <= '0;
            r_hi    <= n_clamp;
        end
        if (i_cmd_dp.step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_cmd_dp.issue || i_cmd_dp.step) begin
            r_mid <= thr_raddr;
        end
        if (i_cmd_dp.cnt_rd) begin
            r_cnt_vld_q <= r_cnt_vld[cnt_addr];
            r_cnt_addr  <= cnt_addr;
        end
        if (i_cmd_dp.res_set) begin
            unique case (i_cmd_dp.res_sel)
                RES_LOAD, RES_BAD_RD: begin
                    r_res_hit   <= 1'b0;
                    r_res_bin   <= r_index;
                    r_res_count <= '0;
                end
                RES_MISS: begin
                    r_res_hit   <= 1'b0;
                    r_res_bin   <= '0;
                    r_res_count <= '0;
                end
                RES_HIT_CNT: begin
                    r_res_hit   <= 1'b1;
                    r_res_bin   <= BIN_W'(r_cnt_addr);
                    r_res_count <= cnt_inc;
                end
                RES_READ: begin
                    r_res_hit   <= 1'b1;
                    r_res_bin   <= r_index;
                    r_res_count <= cnt_cur;
                end
                default: begin
                    r_res_hit   <= 1'b0;
                    r_res_bin   <= '0;
                    r_res_count <= '0;
                end
            endcase
        end
        if (i_cmd_dp.out_load) begin
            r_out_hit   <= r_res_hit;
            r_out_bin   <= r_res_bin;
            r_out_count <= r_res_count;
        end
    end

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_dp.step |-> n_lo <= n_hi)
        else $error("search range inverted");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_dp.issue |-> (mid_cur < r_hi && mid_cur >= r_lo))
        else $error("probe outside search range");

    a_hit_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> N_W'(r_cnt_addr) < r_n)
        else $error("count update beyond bins in use");

endmodule

`default_nettype wire

// ===== design/cdf_table_sample_binning_unit.sv =====
// Top level of the CDF table sample binning unit.
// Joins csb_ctrl and csb_dp; uses csb_pkg.
//
// Input stream (s_axis): cmd in tuser, index and value in tdata. cmd 0 loads
// a threshold, cmd 1 bins a sample by binary search over the first
// bins_in_use thresholds (at most 128), cmd 2 reads a bin count, cmd 3 is a no-op.
// Output stream (m_axis): hit in tuser, bin and count in tdata, one result
// per input transfer, in order.
// Config channel (i_cfg_*): writes bins_in_use; always ready, take it only
// while the unit is idle. Resets to 100.
// A sample search takes a data-dependent number of steps over the threshold
// RAM read port, at most ceil(log2(n + 1)) for n bins in use, so 8 for 128
// bins. One item is in work at a time, and the next input transfer waits for
// the result to enter the output register.
// Reset clears all bin counts at once and empties the output register;
// thresholds hold nothing until loaded. When the receiver stalls, the result
// holds in the output register, one more item can be taken and finished,
// and it then waits until the output register frees.
`default_nettype none

module cdf_table_sample_binning_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,     // bins_in_use
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [6:0] index, [23:7] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [6:0] bin, [30:7] count, [31] zero
    output      logic        m_axis_tuser    // [0] hit
);
    import csb_pkg::*;

    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;
    logic [BIN_W-1:0]     out_bin;
    logic [COUNT_W-1:0]   out_count;

    assign m_axis_tdata = {1'b0, out_count, out_bin};

    csb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    csb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (s_axis_tuser),
        .i_index     (s_axis_tdata[6:0]),
        .i_value     (s_axis_tdata[23:7]),
        .o_hit       (m_axis_tuser),
        .o_bin       (out_bin),
        .o_count     (out_count),
        .i_cmd_dp    (dp_cmd),
        .o_sts       (dp_sts)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for cdf_table_sample_binning_unit: random and directed
// transfers against a behavioral histogram predictor held in a scoreboard class.
// Depends on csb_pkg and the unit's top level only.
`timescale 1ns / 1ps

typedef struct packed {
    logic                         hit;
    logic [csb_pkg::BIN_W-1:0]   bin;
    logic [csb_pkg::COUNT_W-1:0] count;
} t_bin_result;

class histogram_scoreboard;
    logic [csb_pkg::VALUE_W-1:0] thresholds [csb_pkg::MAX_BINS];
    logic [csb_pkg::COUNT_W-1:0] counts [csb_pkg::MAX_BINS];
    logic [csb_pkg::CFG_W-1:0]   bins_in_use;
    t_bin_result                 pending_results [$];
    int                          errors;

    function new();
        for (int i = 0; i < csb_pkg::MAX_BINS; i++) begin
            thresholds[i] = '0;
            counts[i]     = '0;
        end
        bins_in_use = csb_pkg::BINS_RST;
        errors      = 0;
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function int searched_bins();
        return (bins_in_use > csb_pkg::MAX_BINS) ? csb_pkg::MAX_BINS : int'(bins_in_use);
    endfunction

    function void note_request(csb_pkg::t_cmd cmd, logic [6:0] idx, logic [16:0] val);
        t_bin_result r;
        int          limit;
        int          j;
        r = '0;
        case (cmd)
            csb_pkg::CMD_LOAD: begin
                thresholds[idx] = val;
                r.bin = idx;
            end
            csb_pkg::CMD_BIN: begin
                limit = searched_bins();
                j = 0;
                while (j < limit && thresholds[j] <= val) j++;
                if (j < limit) begin
                    if (counts[j] != '1) counts[j] = counts[j] + 1'b1;
                    r.hit   = 1'b1;
                    r.bin   = j[6:0];
                    r.count = counts[j];
                end
            end
            csb_pkg::CMD_READ: begin
                r.hit   = 1'b1;
                r.bin   = idx;
                r.count = counts[idx];
            end
            default: ;
        endcase
        pending_results = {pending_results, r};
    endfunction

    task check_result(logic hit, logic [6:0] bin, logic [23:0] count);
        t_bin_result e;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result hit=%0d bin=%0d count=%0d", hit, bin, count));
            return;
        end
        e = pending_results.pop_front();
        if (hit !== e.hit)
            report($sformatf("hit got %0d want %0d", hit, e.hit));
        if (bin !== e.bin)
            report($sformatf("bin got %0d want %0d", bin, e.bin));
        if (count !== e.count)
            report($sformatf("count got %0d want %0d", count, e.count));
    endtask
endclass

module testbench;
    import csb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    histogram_scoreboard sb;
    int                  src_idle_pct;
    int                  sink_idle_pct;
    int                  cycles = 0;

    cdf_table_sample_binning_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[30:7]);
    end

    task automatic send_item(t_cmd cmd, logic [6:0] idx, logic [16:0] val);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(cmd, idx, val);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_bins(logic [7:0] n);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.bins_in_use = n;
    endtask

    function automatic logic [7:0] pick_bins();
        case ($urandom_range(0, 9))
            0:       return 8'd1;
            1:       return 8'd128;
            2:       return 8'd255;
            3:       return 8'd0;
            default: return 8'($urandom_range(2, 127));
        endcase
    endfunction

    task automatic send_random_item();
        int          r;
        int          s;
        int          j;
        int          limit;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [16:0] v;
        logic [6:0]  idx;
        r   = $urandom_range(0, 99);
        idx = 7'($urandom_range(0, 127));
        if (r < 12) begin
            // keep the table non-decreasing
            lo = (idx == 0) ? 17'd0 : sb.thresholds[idx-1];
            if (idx == 127)
                hi = ($urandom_range(0, 3) == 0) ? 17'h1FFFF : 17'd65536;
            else
                hi = sb.thresholds[idx+1];
            if (hi < lo) hi = lo;
            v = 17'($urandom_range(hi, lo));
            send_item(CMD_LOAD, idx, v);
        end else if (r < 72) begin
            limit = sb.searched_bins();
            s = $urandom_range(0, 9);
            if (s < 4) begin
                v = 17'($urandom_range(0, 65536));
            end else if (s < 8 && limit > 0) begin
                j = $urandom_range(0, limit - 1);
                v = sb.thresholds[j];
                case ($urandom_range(0, 2))
                    0: if (v != '0) v = v - 1'b1;
                    2: if (v != '1) v = v + 1'b1;
                    default: ;
                endcase
            end else if (s == 9) begin
                v = 17'($urandom_range(0, 17'h1FFFF));
            end else begin
                v = ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
            end
            send_item(CMD_BIN, 7'($urandom_range(0, 127)), v);
        end else if (r < 94) begin
            send_item(CMD_READ, idx, 17'($urandom_range(0, 17'h1FFFF)));
        end else begin
            send_item(CMD_NONE, idx, 17'($urandom_range(0, 17'h1FFFF)));
        end
    endtask

    task automatic run_phase(int src, int snk);
        src_idle_pct  = src;
        sink_idle_pct = snk;
        repeat (7) begin
            drain();
            write_bins(pick_bins());
            repeat (41) send_random_item();
        end
    endtask

    initial begin
        logic [16:0] v;
        sb            = new();
        src_idle_pct  = 14;
        sink_idle_pct = 71;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table so that any search stays on loaded entries
        v = 17'($urandom_range(1, 400));
        for (int i = 0; i < MAX_BINS; i++) begin
            send_item(CMD_LOAD, 7'(i), v);
            if ($urandom_range(0, 3) != 0) v = v + 17'($urandom_range(1, 1364));
            if (v > 17'd65536) v = 17'd65536;
        end

        send_item(CMD_BIN, 7'd0, 17'd0);
        send_item(CMD_BIN, 7'd127, 17'd65535);
        send_item(CMD_BIN, 7'd0, 17'd65536);
        send_item(CMD_BIN, 7'd0, 17'h1FFFF);
        send_item(CMD_BIN, 7'd0, sb.thresholds[0]);
        send_item(CMD_BIN, 7'd0, sb.thresholds[99]);
        send_item(CMD_BIN, 7'd0, sb.thresholds[99] - 1'b1);
        send_item(CMD_READ, 7'd0, 17'd0);
        send_item(CMD_READ, 7'd127, 17'h1FFFF);
        send_item(CMD_READ, 7'd5, 17'd0);
        send_item(CMD_NONE, 7'h7F, 17'h1FFFF);
        send_item(CMD_LOAD, 7'd127, 17'h1FFFF);
        drain();
        write_bins(8'd255);
        send_item(CMD_BIN, 7'd0, 17'h1FFFE);
        send_item(CMD_BIN, 7'd0, 17'h1FFFF);
        drain();
        write_bins(8'd0);
        send_item(CMD_BIN, 7'd0, 17'd0);
        send_item(CMD_BIN, 7'd0, 17'd65535);
        drain();
        write_bins(8'd1);
        send_item(CMD_BIN, 7'd0, 17'd0);
        send_item(CMD_BIN, 7'd0, sb.thresholds[0]);
        send_item(CMD_READ, 7'd0, 17'd0);
        drain();
        write_bins(8'd128);
        send_item(CMD_BIN, 7'd0, sb.thresholds[127] - 1'b1);

        run_phase(14, 71);
        run_phase(71, 14);
        run_phase(0, 0);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
